@@ rtl/core/kped_pkg.sv @@
// Shared types and codes for the key press event detector.
// Used by the channel interfaces, the step logic and the top level.
// No dependencies.
package kped_pkg;

  // field widths of the channels
  localparam int unsigned KEY_IDX_W  = 2;
  localparam int unsigned PIN_W      = 4;
  localparam int unsigned KEY_NUM_W  = 3;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned DEB_W      = 8;
  localparam int unsigned HOLD_W     = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned PHASE_W    = 2;

  // press phase codes
  localparam logic [PHASE_W-1:0] PHASE_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_PRESS = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_HOLD  = 2'd2;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SHORT  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_LONG   = 2'd2;
  localparam logic [EVENT_W-1:0] EV_REPEAT = 2'd3;

  // item kinds
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;

  // reset values of the configuration registers
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 8'd2;
  localparam logic [HOLD_W-1:0] LONG_RST     = 12'd50;
  localparam logic [HOLD_W-1:0] REPEAT_RST   = 12'd20;

  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

  typedef struct packed {
    logic                 mode;
    logic [KEY_IDX_W-1:0] edge_key;
    logic [PIN_W-1:0]     pin_levels;
  } kped_item_t;

  typedef struct packed {
    logic [KEY_NUM_W-1:0] key_number;
    logic [EVENT_W-1:0]   event_code;
    logic                 pin_level;
  } kped_result_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [HOLD_W-1:0] long_press_ticks;
    logic [HOLD_W-1:0] repeat_ticks;
  } kped_cfg_t;

  typedef struct packed {
    logic                 press_latched;
    logic [KEY_NUM_W-1:0] latched_key;
    logic [PHASE_W-1:0]   press_phase;
    logic [HOLD_W-1:0]    hold_count;
    logic [DEB_W-1:0]     debounce_count;
  } kped_state_t;

endpackage

@@ rtl/core/kped_in_if.sv @@
// Input channel of the key press event detector: edge and tick items.
// Depends on kped_pkg for field widths.
interface kped_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [kped_pkg::KEY_IDX_W-1:0] edge_key;
  logic [kped_pkg::PIN_W-1:0]     pin_levels;

  modport source (output valid, output mode, output edge_key, output pin_levels,
                  input ready);
  modport sink   (input valid, input mode, input edge_key, input pin_levels,
                  output ready);
endinterface

@@ rtl/core/kped_out_if.sv @@
// Result channel of the key press event detector: one event beat per item.
// Depends on kped_pkg for field widths.
interface kped_out_if;
  logic                           valid;
  logic                           ready;
  logic [kped_pkg::KEY_NUM_W-1:0] key_number;
  logic [kped_pkg::EVENT_W-1:0]   event_code;
  logic                           pin_level;

  modport source (output valid, output key_number, output event_code,
                  output pin_level, input ready);
  modport sink   (input valid, input key_number, input event_code,
                  input pin_level, output ready);
endinterface

@@ rtl/core/kped_cfg_if.sv @@
// Configuration write channel of the key press event detector.
// Depends on kped_pkg for index and data widths.
interface kped_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kped_pkg::CFG_IDX_W-1:0]  index;
  logic [kped_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/kped_step.sv @@
// Next-state and event logic for one item of the key press event detector.
// Purely combinational; depends on kped_pkg for types and codes.
module kped_step #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  kped_pkg::kped_item_t   item,
  input  kped_pkg::kped_cfg_t    cfg,
  input  kped_pkg::kped_state_t  state,
  output kped_pkg::kped_state_t  state_nxt,
  output kped_pkg::kped_result_t result
);

  localparam logic [3:0] NumKeysW = 4'(NUM_KEYS);

  logic [kped_pkg::KEY_NUM_W-1:0] pin_idx;
  logic                           level;
  logic [kped_pkg::HOLD_W-1:0]    hold_inc;
  logic [kped_pkg::EVENT_W-1:0]   ev;

  // pin of the latched key on a tick; keys without a pin bit read as released
  assign pin_idx = state.latched_key - kped_pkg::KEY_NUM_W'(1);

  always_comb begin
    if ((item.mode == kped_pkg::MODE_TICK) && state.press_latched &&
        (state.latched_key != '0) && !pin_idx[2]) begin
      level = item.pin_levels[pin_idx[1:0]];
    end else begin
      level = 1'b1;
    end
  end

  // saturating hold counter
  assign hold_inc = (state.hold_count == kped_pkg::HOLD_MAX) ?
                    kped_pkg::HOLD_MAX : state.hold_count + kped_pkg::HOLD_W'(1);

  // state update and event
  always_comb begin
    state_nxt = state;
    ev        = kped_pkg::EV_NONE;
    if (item.mode == kped_pkg::MODE_EDGE) begin
      if (!state.press_latched && ({2'b00, item.edge_key} < NumKeysW)) begin
        state_nxt.press_latched  = 1'b1;
        state_nxt.latched_key    = {1'b0, item.edge_key} + kped_pkg::KEY_NUM_W'(1);
        state_nxt.hold_count     = '0;
        state_nxt.debounce_count = '0;
      end
    end else if (state.press_latched) begin
      if (!level) begin
        if (state.debounce_count < cfg.debounce_ticks) begin
          state_nxt.debounce_count = state.debounce_count + kped_pkg::DEB_W'(1);
        end else begin
          case (state.press_phase)
            kped_pkg::PHASE_IDLE: begin
              state_nxt.press_phase = kped_pkg::PHASE_PRESS;
              state_nxt.hold_count  = '0;
            end
            kped_pkg::PHASE_PRESS: begin
              if (hold_inc >= cfg.long_press_ticks) begin
                state_nxt.press_phase = kped_pkg::PHASE_HOLD;
                state_nxt.hold_count  = '0;
                ev                    = kped_pkg::EV_LONG;
              end else begin
                state_nxt.hold_count = hold_inc;
              end
            end
            kped_pkg::PHASE_HOLD: begin
              if (hold_inc >= cfg.repeat_ticks) begin
                state_nxt.hold_count = '0;
                ev                   = kped_pkg::EV_REPEAT;
              end else begin
                state_nxt.hold_count = hold_inc;
              end
            end
            default: begin
              state_nxt = state;
            end
          endcase
        end
      end else begin
        // release: short press only from the confirmed phase
        if (state.press_phase == kped_pkg::PHASE_PRESS) begin
          ev = kped_pkg::EV_SHORT;
        end
        state_nxt = '0;
      end
    end
  end

  assign result.event_code = ev;
  assign result.key_number = (ev != kped_pkg::EV_NONE) ? state.latched_key : '0;
  assign result.pin_level  = level;

endmodule

@@ rtl/core/key_press_event_detector.sv @@
// Top level of the key press event detector: input register, step logic, result register.
// Depends on kped_pkg, kped_in_if, kped_out_if, kped_cfg_if and kped_step.
//
// Takes one edge or tick beat per clock while in_bus.ready is high and gives exactly one
// result beat for each, in order. A beat is held in the input register and is then
// evaluated against the press state in a single pass, which also updates that state and
// loads the result register, from which out_bus offers the result. in_bus.ready only
// drops while both registers hold beats and the result is not being taken, so with
// out_bus.ready held high the block sustains one beat per cycle. Configuration writes
// are always taken and act on items evaluated afterwards.
module key_press_event_detector #(
  parameter int unsigned NUM_KEYS = 4
) (
  input logic       clk,
  input logic       rst_n,
  kped_in_if.sink   in_bus,
  kped_out_if.source out_bus,
  kped_cfg_if.sink  cfg_bus
);

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  kped_pkg::kped_item_t   s1_item_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  kped_pkg::kped_result_t out_res_r;
  kped_pkg::kped_state_t  state_r;
  kped_pkg::kped_state_t  state_nxt;
  kped_pkg::kped_result_t step_res;
  kped_pkg::kped_cfg_t    cfg_r;
  logic                   s1_go;
  logic                   in_beat;

  // handshake
  assign s1_go        = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !s1_valid_r || s1_go;
  assign in_beat      = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  assign s1_valid_nxt  = in_beat ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_valid_r && s1_go) ? 1'b1 :
                         (out_bus.ready ? 1'b0 : out_valid_r);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_item_r.mode       <= in_bus.mode;
      s1_item_r.edge_key   <= in_bus.edge_key;
      s1_item_r.pin_levels <= in_bus.pin_levels;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= kped_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ticks <= kped_pkg::LONG_RST;
      cfg_r.repeat_ticks     <= kped_pkg::REPEAT_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        kped_pkg::CFG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_bus.data[kped_pkg::DEB_W-1:0];
        kped_pkg::CFG_LONG:     cfg_r.long_press_ticks <= cfg_bus.data;
        kped_pkg::CFG_REPEAT:   cfg_r.repeat_ticks <= cfg_bus.data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // single-pass evaluation
  kped_step #(
    .NUM_KEYS (NUM_KEYS)
  ) u_step (
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  // press state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_valid_r && s1_go) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go) begin
      out_res_r <= step_res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.key_number = out_res_r.key_number;
  assign out_bus.event_code = out_res_r.event_code;
  assign out_bus.pin_level  = out_res_r.pin_level;

  // no latched key means nothing else is held
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.press_latched |-> (state_r.latched_key == '0) &&
                               (state_r.press_phase == kped_pkg::PHASE_IDLE))
    else $error("press state not clear while no key latched");

  // a latched key is a valid key number
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.press_latched |-> (state_r.latched_key != '0) &&
                              (32'(state_r.latched_key) <= NUM_KEYS))
    else $error("latched key out of range");

  // every event names its key
  a_event_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.event_code != kped_pkg::EV_NONE) |->
      out_res_r.key_number != '0)
    else $error("event without key number");

  // short press comes with a released line, long and repeat with a held one
  a_event_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.event_code != kped_pkg::EV_NONE) |->
      (out_res_r.pin_level == (out_res_r.event_code == kped_pkg::EV_SHORT)))
    else $error("event does not match sampled line level");

  // a stalled input beat stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r)
    else $error("input register dropped a beat");

endmodule

@@ dv/kped_checker.sv @@
// Scoreboard for the key press event detector: watches the input, result and
// configuration channels, predicts each event beat and compares it.
// Depends on kped_pkg, kped_in_if, kped_out_if and kped_cfg_if.
module kped_checker #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic clk,
  input  logic rst_n,
  kped_in_if   in_mon,
  kped_out_if  out_mon,
  kped_cfg_if  cfg_mon,
  output int   err_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import kped_pkg::*;

  localparam int MAX_REPORTS = 10;

  // register copies
  logic [DEB_W-1:0]  debounce_lim;
  logic [HOLD_W-1:0] long_lim;
  logic [HOLD_W-1:0] repeat_lim;

  // press tracking
  logic                 key_held;
  logic [KEY_NUM_W-1:0] held_key;
  logic [PHASE_W-1:0]   hold_phase;
  logic [HOLD_W-1:0]    held_ticks;
  logic [DEB_W-1:0]     settle_ticks;

  kped_result_t expected_events[$];
  int           mismatch_total;

  // advance the press tracking by one beat and return the event it gives
  function automatic kped_result_t next_key_event(input kped_item_t beat);
    kped_result_t         ev;
    logic [KEY_NUM_W-1:0] bit_idx;
    logic                 level;
    ev.key_number = '0;
    ev.event_code = EV_NONE;
    ev.pin_level  = 1'b1;
    if (beat.mode == MODE_EDGE) begin
      // only the first falling line is latched
      if (!key_held && beat.edge_key < NUM_KEYS) begin
        key_held     = 1'b1;
        held_key     = KEY_NUM_W'(beat.edge_key) + 1'b1;
        held_ticks   = '0;
        settle_ticks = '0;
      end
    end else if (key_held) begin
      bit_idx = held_key - 1'b1;
      if (held_key >= 1 && bit_idx < PIN_W) begin
        level = beat.pin_levels[bit_idx];
      end else begin
        level = 1'b1;
      end
      ev.pin_level = level;
      if (!level) begin
        if (settle_ticks < debounce_lim) begin
          settle_ticks = settle_ticks + 1'b1;
        end else begin
          case (hold_phase)
            PHASE_IDLE: begin
              hold_phase = PHASE_PRESS;
              held_ticks = '0;
            end
            PHASE_PRESS: begin
              held_ticks = (held_ticks == HOLD_MAX) ? HOLD_MAX : held_ticks + 1'b1;
              if (held_ticks >= long_lim) begin
                hold_phase    = PHASE_HOLD;
                ev.event_code = EV_LONG;
                held_ticks    = '0;
              end
            end
            PHASE_HOLD: begin
              held_ticks = (held_ticks == HOLD_MAX) ? HOLD_MAX : held_ticks + 1'b1;
              if (held_ticks >= repeat_lim) begin
                ev.event_code = EV_REPEAT;
                held_ticks    = '0;
              end
            end
            default: ;
          endcase
        end
        if (ev.event_code != EV_NONE) ev.key_number = held_key;
      end else begin
        // release: short press only from the confirmed, not yet long phase
        if (hold_phase == PHASE_PRESS) begin
          ev.event_code = EV_SHORT;
          ev.key_number = held_key;
        end
        key_held     = 1'b0;
        held_key     = '0;
        hold_phase   = PHASE_IDLE;
        held_ticks   = '0;
        settle_ticks = '0;
      end
    end
    return ev;
  endfunction

  always @(posedge clk) begin
    kped_result_t got;
    kped_result_t want;
    kped_item_t   beat;
    if (!rst_n) begin
      debounce_lim   = DEBOUNCE_RST;
      long_lim       = LONG_RST;
      repeat_lim     = REPEAT_RST;
      key_held       = 1'b0;
      held_key       = '0;
      hold_phase     = PHASE_IDLE;
      held_ticks     = '0;
      settle_ticks   = '0;
      mismatch_total = 0;
      expected_events.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got.key_number = out_mon.key_number;
        got.event_code = out_mon.event_code;
        got.pin_level  = out_mon.pin_level;
        if (expected_events.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= MAX_REPORTS)
            $display("%0t: unexpected event beat key=%0d code=%0d pin=%0d", $realtime,
                     got.key_number, got.event_code, got.pin_level);
        end else begin
          want = expected_events.pop_front();
          if (got.key_number !== want.key_number || got.event_code !== want.event_code ||
              got.pin_level !== want.pin_level) begin
            mismatch_total++;
            if (mismatch_total <= MAX_REPORTS)
              $display("%0t: event mismatch exp key=%0d code=%0d pin=%0d got key=%0d code=%0d pin=%0d",
                       $realtime, want.key_number, want.event_code, want.pin_level,
                       got.key_number, got.event_code, got.pin_level);
          end
        end
      end
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_DEBOUNCE: debounce_lim = cfg_mon.data[DEB_W-1:0];
          CFG_LONG:     long_lim     = cfg_mon.data[HOLD_W-1:0];
          CFG_REPEAT:   repeat_lim   = cfg_mon.data[HOLD_W-1:0];
          default: ;
        endcase
      end
      // input beat
      if (in_mon.valid && in_mon.ready) begin
        beat.mode       = in_mon.mode;
        beat.edge_key   = in_mon.edge_key;
        beat.pin_levels = in_mon.pin_levels;
        expected_events.push_back(next_key_event(beat));
      end
    end
    err_count     = mismatch_total;
    pending_count = expected_events.size();
  end

endmodule

@@ dv/tb_top.sv @@
// Top of the key press event detector testbench: clock, reset, stimulus and verdict.
// Depends on kped_pkg, the channel interfaces, key_press_event_detector and kped_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kped_pkg::*;

  localparam int unsigned NUM_KEYS     = 4;
  localparam int unsigned BEATS_PER_RUN = 140;
  localparam int unsigned SPAN_CAP     = 400;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int          err_count;
  int          pending_count;

  // mirror of the thresholds, used only to shape press lengths
  int unsigned cur_deb;
  int unsigned cur_long;
  int unsigned cur_rep;

  kped_in_if  in_bus ();
  kped_out_if out_bus ();
  kped_cfg_if cfg_bus ();

  key_press_event_detector #(.NUM_KEYS(NUM_KEYS)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  kped_checker #(.NUM_KEYS(NUM_KEYS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .cfg_mon       (cfg_bus),
    .err_count     (err_count),
    .pending_count (pending_count)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side back-pressure
  always @(negedge clk) begin
    out_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // run limit
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // one input beat, with random sender gaps before it
  task automatic drive_item(input logic mode, input logic [KEY_IDX_W-1:0] key,
                            input logic [PIN_W-1:0] pins);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= mode;
    in_bus.edge_key   <= key;
    in_bus.pin_levels <= pins;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // ticks with the given key's line low, other lines random
  task automatic hold_low(input logic [KEY_IDX_W-1:0] key, input int unsigned n);
    logic [PIN_W-1:0] pins;
    for (int unsigned i = 0; i < n; i++) begin
      pins      = PIN_W'($urandom_range(15));
      pins[key] = 1'b0;
      drive_item(MODE_TICK, KEY_IDX_W'($urandom_range(3)), pins);
    end
  endtask

  // one tick with the given key's line high
  task automatic release_key(input logic [KEY_IDX_W-1:0] key);
    logic [PIN_W-1:0] pins;
    pins      = PIN_W'($urandom_range(15));
    pins[key] = 1'b1;
    drive_item(MODE_TICK, KEY_IDX_W'($urandom_range(3)), pins);
  endtask

  task automatic press_edge(input logic [KEY_IDX_W-1:0] key);
    drive_item(MODE_EDGE, key, PIN_W'($urandom_range(15)));
  endtask

  // stop sending and wait until every event beat is back
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  // rewrite all thresholds while the block is idle
  task automatic set_thresholds(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] lng,
                                input logic [HOLD_W-1:0] rep, input bit poke_unused);
    logic [CFG_DATA_W-1:0] data;
    settle();
    // unused upper bits of the debounce write carry noise
    data            = CFG_DATA_W'($urandom_range(4095));
    data[DEB_W-1:0] = deb;
    write_reg(CFG_DEBOUNCE, data);
    write_reg(CFG_LONG, lng);
    write_reg(CFG_REPEAT, rep);
    if (poke_unused) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(4095)));
    cfg_bus.valid <= 1'b0;
    cur_deb  = deb;
    cur_long = lng;
    cur_rep  = rep;
  endtask

  // mostly full presses of random length, some noise and bounces
  task automatic run_random(input int unsigned quota);
    int unsigned          done_beats;
    int unsigned          span;
    int unsigned          n;
    int unsigned          burst;
    logic [KEY_IDX_W-1:0] key;
    done_beats = 0;
    while (done_beats < quota) begin
      if ($urandom_range(99) < 80) begin
        key = KEY_IDX_W'($urandom_range(NUM_KEYS - 1));
        press_edge(key);
        span = cur_deb + cur_long + 3 * cur_rep + 4;
        if (span > SPAN_CAP) span = SPAN_CAP;
        n = $urandom_range(span);
        // bounce: line comes back up after at most debounce + 1 low ticks
        if ($urandom_range(9) == 0) n = $urandom_range(cur_deb + 1);
        hold_low(key, n);
        if ($urandom_range(9) != 0) release_key(key);
        done_beats += n + 2;
      end else begin
        burst = $urandom_range(1, 8);
        for (int unsigned i = 0; i < burst; i++)
          drive_item(1'($urandom_range(1)), KEY_IDX_W'($urandom_range(3)),
                     PIN_W'($urandom_range(15)));
        done_beats += burst;
      end
    end
  endtask

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.mode       = MODE_EDGE;
    in_bus.edge_key   = '0;
    in_bus.pin_levels = '1;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_DEBOUNCE;
    cfg_bus.data      = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    cur_deb           = DEBOUNCE_RST;
    cur_long          = LONG_RST;
    cur_rep           = REPEAT_RST;
    rst_n             = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: tick with nothing latched, edge while latched, short press at reset values
    drive_item(MODE_TICK, 2'd0, 4'h0);
    press_edge(2'd3);
    press_edge(2'd0);
    hold_low(2'd3, 3);
    release_key(2'd3);

    // long press, repeats, then release from long hold
    set_thresholds(8'd1, 12'd2, 12'd1, 1'b0);
    press_edge(2'd0);
    hold_low(2'd0, 6);
    release_key(2'd0);

    // release during debounce
    press_edge(2'd1);
    hold_low(2'd1, 1);
    release_key(2'd1);

    // long threshold lowered mid-press
    set_thresholds(8'd1, HOLD_MAX, 12'd1, 1'b0);
    press_edge(2'd2);
    hold_low(2'd2, 3);
    set_thresholds(8'd1, 12'd1, 12'd1, 1'b0);
    hold_low(2'd2, 1);
    release_key(2'd2);

    // zero thresholds
    set_thresholds(8'd0, 12'd0, 12'd0, 1'b0);
    press_edge(2'd1);
    hold_low(2'd1, 3);
    release_key(2'd1);

    // random runs over several settings and idling mixes
    for (int stage = 0; stage < 6; stage++) begin
      case (stage % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 74;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 74;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct     = 25;
        end
      endcase
      case (stage)
        0:       set_thresholds(8'd3, 12'd10, 12'd4, 1'b0);
        1:       set_thresholds(8'd0, 12'd1, 12'd1, 1'b0);
        2:       set_thresholds(8'd255, 12'd200, 12'd60, 1'b0);
        3:       set_thresholds(8'd1, 12'd5, 12'd3, 1'b1);
        4:       set_thresholds(8'd0, 12'd0, 12'd0, 1'b0);
        default: set_thresholds(8'd6, 12'd20, 12'd7, 1'b1);
      endcase
      // at the largest debounce, one press held through a long press and a repeat
      if (cur_deb == 255) begin
        press_edge(2'd3);
        hold_low(2'd3, cur_deb + 1 + cur_long + cur_rep + 5);
        release_key(2'd3);
      end
      run_random(BEATS_PER_RUN);
    end

    // drain and verdict
    send_idle_pct = 0;
    stall_pct     = 0;
    settle();
    repeat (8) @(negedge clk);
    if (err_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/kped_pkg.sv
rtl/core/kped_in_if.sv
rtl/core/kped_out_if.sv
rtl/core/kped_cfg_if.sv
rtl/core/kped_step.sv
rtl/core/key_press_event_detector.sv
dv/kped_checker.sv
dv/tb_top.sv
